/* rtl/mrfd_pkg.sv */
// shared types and constants for the motor response frame decoder
`default_nettype none

package mrfd_pkg;

    localparam int HEAD_BYTES  = 6;
    localparam int COUNT_W     = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // reply command codes
    localparam logic [7:0] CMD_ENCODER = 8'h31;
    localparam logic [7:0] CMD_TARGET_A = 8'h33;
    localparam logic [7:0] CMD_TARGET_B = 8'h34;
    localparam logic [7:0] CMD_SPEED   = 8'h35;
    localparam logic [7:0] CMD_ANGLE   = 8'h36;
    localparam logic [7:0] CMD_POS_ERR = 8'h37;
    localparam logic [7:0] CMD_STATUS  = 8'h3A;
    localparam logic [7:0] CMD_VOLTAGE = 8'h24;

    // exact reply lengths
    localparam logic [7:0] LEN_ENCODER = 8'd6;
    localparam logic [7:0] LEN_TARGET  = 8'd7;
    localparam logic [7:0] LEN_SPEED   = 8'd6;
    localparam logic [7:0] LEN_ANGLE   = 8'd8;
    localparam logic [7:0] LEN_POS_ERR = 8'd8;
    localparam logic [7:0] LEN_STATUS  = 8'd4;
    localparam logic [7:0] LEN_VOLTAGE = 8'd5;

    // acknowledge codes carried in byte 2
    localparam logic [7:0] ACK_BYTE_OK      = 8'h02;
    localparam logic [7:0] ACK_BYTE_COND    = 8'hE2;
    localparam logic [7:0] ACK_BYTE_FORMAT  = 8'hEE;

    localparam logic [9:0] ANGLE_SCALE = 10'd360;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_SPEED   = 3'd1;
    localparam logic [2:0] KIND_ANGLE   = 3'd2;
    localparam logic [2:0] KIND_POS_ERR = 3'd3;
    localparam logic [2:0] KIND_TARGET  = 3'd4;
    localparam logic [2:0] KIND_STATUS  = 3'd5;
    localparam logic [2:0] KIND_ENCODER = 3'd6;
    localparam logic [2:0] KIND_VOLTAGE = 3'd7;

    localparam logic [1:0] ACK_OK       = 2'd0;
    localparam logic [1:0] ACK_COND     = 2'd1;
    localparam logic [1:0] ACK_FORMAT   = 2'd2;
    localparam logic [1:0] ACK_NONE     = 2'd3;

    localparam logic [0:0] REG_DEVICE_ADDRESS   = 1'b0;
    localparam logic [0:0] REG_EXPECTED_ACK_CMD = 1'b1;

    typedef struct packed {
        logic [HEAD_BYTES-1:0][7:0] head;
        logic [COUNT_W-1:0]         len;
    } frame_t;

endpackage

`default_nettype wire

/* rtl/mrfd_front.sv */
// front end: collects received bytes and hands complete frames to the queue
`default_nettype none

module mrfd_front #(
    parameter int RX_BUFFER_BYTES = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              end_of_frame,
    output mrfd_pkg::frame_t       frame,
    output logic                   frame_valid
);

    localparam logic [mrfd_pkg::COUNT_W-1:0] COUNT_MAX =
        mrfd_pkg::COUNT_W'(RX_BUFFER_BYTES);
    localparam logic [mrfd_pkg::COUNT_W-1:0] HEAD_LIMIT =
        mrfd_pkg::COUNT_W'(mrfd_pkg::HEAD_BYTES);

    logic [mrfd_pkg::HEAD_BYTES-1:0][7:0] head_reg;
    logic [mrfd_pkg::HEAD_BYTES-1:0][7:0] head_next;
    logic [mrfd_pkg::COUNT_W-1:0]         count_reg;
    logic [mrfd_pkg::COUNT_W-1:0]         count_sat;
    logic [mrfd_pkg::COUNT_W-1:0]         count_next;

    always_comb
    begin
        head_next = head_reg;
        if (accept && count_reg < HEAD_LIMIT)
        begin
            head_next[count_reg[2:0]] = rx_byte;
        end
        count_sat = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        count_next = count_reg;
        if (accept)
        begin
            count_next = end_of_frame ? '0 : count_sat;
        end
    end

    // the frame snapshot already counts the last byte, and holds it when within the head
    assign frame.head  = head_next;
    assign frame.len   = count_sat;
    assign frame_valid = accept && end_of_frame;

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mrfd_queue.sv */
// short frame queue between the front and back ends
`default_nettype none

module mrfd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire mrfd_pkg::frame_t  wr_data,
    input  wire logic              rd_en,
    output mrfd_pkg::frame_t       rd_data,
    output logic                   full,
    output logic                   empty
);

    mrfd_pkg::frame_t                   entry_reg [mrfd_pkg::QUEUE_DEPTH];
    logic [mrfd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [mrfd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [mrfd_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [mrfd_pkg::QUEUE_CNT_W-1:0]   count_next;

    assign full    = count_reg == mrfd_pkg::QUEUE_CNT_W'(mrfd_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mrfd_back.sv */
// back end: decodes frames, updates held values and presents the result
`default_nettype none

module mrfd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mrfd_pkg::frame_t    frame,
    input  wire logic                frame_avail,
    output logic                     frame_take,
    input  wire logic                cfg_valid,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [7:0]          cfg_data,
    input  wire logic                pop,
    output logic                     empty,
    output logic [2:0]               update_kind,
    output logic [1:0]               ack_status,
    output logic signed [16:0]       speed,
    output logic signed [40:0]       angle_q16,
    output logic signed [15:0]       position_error,
    output logic signed [31:0]       target_position,
    output logic [7:0]               status_flags,
    output logic [15:0]              encoder_value,
    output logic [15:0]              bus_voltage
);

    logic [7:0]         dev_addr_reg;
    logic [7:0]         ack_cmd_reg;
    logic               out_valid_reg;

    logic [2:0]         kind_reg;
    logic [1:0]         ack_reg;
    logic [16:0]        speed_reg;
    logic [40:0]        angle_reg;
    logic [15:0]        pos_error_reg;
    logic [31:0]        target_reg;
    logic [7:0]         status_reg;
    logic [15:0]        encoder_reg;
    logic [15:0]        voltage_reg;

    logic [2:0]         kind_next;
    logic [1:0]         ack_next;
    logic               addr_match;
    logic [15:0]        word34;
    logic [15:0]        word23;
    logic [31:0]        word2345;
    logic signed [40:0] angle_prod;
    logic [16:0]        speed_mag;

    assign frame_take = frame_avail && (!out_valid_reg || pop);

    assign addr_match = frame.head[0] == dev_addr_reg;
    assign word34     = {frame.head[3], frame.head[4]};
    assign word23     = {frame.head[2], frame.head[3]};
    assign word2345   = {frame.head[2], frame.head[3], frame.head[4], frame.head[5]};
    assign speed_mag  = {1'b0, word34};
    assign angle_prod = 41'($signed(word2345)) * $signed(41'(mrfd_pkg::ANGLE_SCALE));

    always_comb
    begin
        kind_next = mrfd_pkg::KIND_NONE;
        if (addr_match)
        begin
            unique case (frame.head[1])
                mrfd_pkg::CMD_SPEED:
                    if (frame.len == mrfd_pkg::LEN_SPEED) kind_next = mrfd_pkg::KIND_SPEED;
                mrfd_pkg::CMD_ANGLE:
                    if (frame.len == mrfd_pkg::LEN_ANGLE) kind_next = mrfd_pkg::KIND_ANGLE;
                mrfd_pkg::CMD_POS_ERR:
                    if (frame.len == mrfd_pkg::LEN_POS_ERR) kind_next = mrfd_pkg::KIND_POS_ERR;
                mrfd_pkg::CMD_TARGET_A, mrfd_pkg::CMD_TARGET_B:
                    if (frame.len == mrfd_pkg::LEN_TARGET) kind_next = mrfd_pkg::KIND_TARGET;
                mrfd_pkg::CMD_STATUS:
                    if (frame.len == mrfd_pkg::LEN_STATUS) kind_next = mrfd_pkg::KIND_STATUS;
                mrfd_pkg::CMD_ENCODER:
                    if (frame.len == mrfd_pkg::LEN_ENCODER) kind_next = mrfd_pkg::KIND_ENCODER;
                mrfd_pkg::CMD_VOLTAGE:
                    if (frame.len == mrfd_pkg::LEN_VOLTAGE) kind_next = mrfd_pkg::KIND_VOLTAGE;
                default:
                    kind_next = mrfd_pkg::KIND_NONE;
            endcase
        end
    end

    always_comb
    begin
        priority if (!addr_match || frame.head[1] != ack_cmd_reg)
            ack_next = mrfd_pkg::ACK_NONE;
        else if (frame.head[2] == mrfd_pkg::ACK_BYTE_OK)
            ack_next = mrfd_pkg::ACK_OK;
        else if (frame.head[2] == mrfd_pkg::ACK_BYTE_COND)
            ack_next = mrfd_pkg::ACK_COND;
        else if (frame.head[2] == mrfd_pkg::ACK_BYTE_FORMAT)
            ack_next = mrfd_pkg::ACK_FORMAT;
        else
            ack_next = mrfd_pkg::ACK_NONE;
    end

    // held values only move when a result slot is free, so they double as the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= 8'd1;
            ack_cmd_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
            kind_reg      <= mrfd_pkg::KIND_NONE;
            ack_reg       <= mrfd_pkg::ACK_NONE;
            speed_reg     <= '0;
            angle_reg     <= '0;
            pos_error_reg <= '0;
            target_reg    <= '0;
            status_reg    <= '0;
            encoder_reg   <= '0;
            voltage_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mrfd_pkg::REG_DEVICE_ADDRESS:   dev_addr_reg <= cfg_data;
                    mrfd_pkg::REG_EXPECTED_ACK_CMD: ack_cmd_reg  <= cfg_data;
                    default:                        dev_addr_reg <= dev_addr_reg;
                endcase
            end
            if (frame_take)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= kind_next;
                ack_reg       <= ack_next;
                unique case (kind_next)
                    mrfd_pkg::KIND_SPEED:
                        speed_reg <= (frame.head[2] != 8'd0) ? 17'd0 - speed_mag : speed_mag;
                    mrfd_pkg::KIND_ANGLE:   angle_reg     <= angle_prod;
                    mrfd_pkg::KIND_POS_ERR: pos_error_reg <= word34;
                    mrfd_pkg::KIND_TARGET:  target_reg    <= word2345;
                    mrfd_pkg::KIND_STATUS:  status_reg    <= frame.head[2];
                    mrfd_pkg::KIND_ENCODER: encoder_reg   <= word34;
                    mrfd_pkg::KIND_VOLTAGE: voltage_reg   <= word23;
                    default:                speed_reg     <= speed_reg;
                endcase
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty           = !out_valid_reg;
    assign update_kind     = kind_reg;
    assign ack_status      = ack_reg;
    assign speed           = $signed(speed_reg);
    assign angle_q16       = $signed(angle_reg);
    assign position_error  = $signed(pos_error_reg);
    assign target_position = $signed(target_reg);
    assign status_flags    = status_reg;
    assign encoder_value   = encoder_reg;
    assign bus_voltage     = voltage_reg;

endmodule

`default_nettype wire

/* rtl/motor_response_frame_decoder_top.sv */
// top level of the motor response frame decoder
//
// input side is a queue: drive rx_byte and end_of_frame with push while full
// is low; end_of_frame marks the last byte of a reply frame (line idle).
// every frame end gives one result; other bytes give none.
// result side is a queue: while empty is low the result ports hold the oldest
// result, and pop takes it. results are update_kind, ack_status and the held
// values, which keep their last decoded contents between frames.
// configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 device address, 1 expected ack command); write only while idle.
// a frame-end byte goes into the frame queue; the back end registers its result
// from there. throughput: one byte per cycle while full is low; the front
// collects bytes, a two-entry frame queue feeds the back end, which decodes
// one frame per cycle when its result register is free or is being popped.
// when pop is held low the back end stops, the frame queue fills and full
// rises; bytes without the end mark are still never lost.
// reset clears the byte count, the queue, the result and all held values;
// the device address returns to 1 and the expected ack command to 0.
`default_nettype none

module motor_response_frame_decoder_top #(
    parameter int RX_BUFFER_BYTES = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               end_of_frame,
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              update_kind,
    output logic [1:0]              ack_status,
    output logic signed [16:0]      speed,
    output logic signed [40:0]      angle_q16,
    output logic signed [15:0]      position_error,
    output logic signed [31:0]      target_position,
    output logic [7:0]              status_flags,
    output logic [15:0]             encoder_value,
    output logic [15:0]             bus_voltage,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    logic              accept;
    mrfd_pkg::frame_t  front_frame;
    logic              front_valid;
    mrfd_pkg::frame_t  queue_frame;
    logic              queue_empty;
    logic              queue_full;
    logic              back_take;

    assign accept    = push && !queue_full;
    assign full      = queue_full;
    assign cfg_ready = 1'b1;

    mrfd_front #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .end_of_frame (end_of_frame),
        .frame        (front_frame),
        .frame_valid  (front_valid)
    );

    mrfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_frame),
        .rd_en   (back_take),
        .rd_data (queue_frame),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    mrfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame           (queue_frame),
        .frame_avail     (!queue_empty),
        .frame_take      (back_take),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pop             (pop),
        .empty           (empty),
        .update_kind     (update_kind),
        .ack_status      (ack_status),
        .speed           (speed),
        .angle_q16       (angle_q16),
        .position_error  (position_error),
        .target_position (target_position),
        .status_flags    (status_flags),
        .encoder_value   (encoder_value),
        .bus_voltage     (bus_voltage)
    );

endmodule

`default_nettype wire
